### design/wti_pkg.sv
`timescale 1ns / 1ps
// shared constants and codes of the waypoint trajectory interpolator
// no dependencies

package wti_pkg;

    localparam int MAX_POINTS = 256;
    localparam int NUM_JOINTS = 6;
    localparam int ANGLE_BITS = 24;

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int JIDX_W  = 3;
    localparam int TIME_W  = 32;
    localparam int ELAP_W  = 34;
    localparam int DT_W    = 16;
    localparam int ALPHA_W = 17;
    localparam int ROW_W   = NUM_JOINTS * ANGLE_BITS;
    localparam int FUNC_W  = 3;
    localparam int PADDR_W = 3;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << (ALPHA_W - 1);

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_START  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_STOP   = 3'd4;

    localparam logic [PADDR_W-1:0] ADDR_LOOP_MODE = 3'd0;

endpackage

### design/wti_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module wti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/waypoint_trajectory_interpolator_top.sv
`timescale 1ns / 1ps
// waypoint trajectory interpolator: waypoint tables, sequencer, shared divide unit
// depends on wti_pkg and wti_ram
//
// channel  direction  handshake             payload
// in       into       in_valid / in_stall   func, point_time, joint_0..5, tick_dt
// out      out of     out_valid / out_stall joint_index, joint_value, joint_valid,
//                                           visible, playing, last
// cfg      into       apb, pready tied high loop_mode at byte address 0
//
// clear, append, start and stop complete in idle; a tick runs the sequencer and
// stalls the input until it is done; a playing tick reads the duration, wraps the
// time in loop mode, searches the segments, divides for alpha and emits each joint;
// a tick that holds the final point emits the joints of that point; the wrap and the
// alpha division share the one shift-subtract unit, and the time table has one read port
// rst_n clears the control state; table contents stay undefined until appended
// in_stall is high from the cycle after a tick is taken until the sequencer is
// back in idle; each joint beat waits while out_stall holds the output register

module waypoint_trajectory_interpolator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [wti_pkg::FUNC_W-1:0]          func,
    input  logic [wti_pkg::TIME_W-1:0]          point_time,
    input  logic signed [wti_pkg::ANGLE_BITS-1:0] joint_0,
    input  logic signed [wti_pkg::ANGLE_BITS-1:0] joint_1,
    input  logic signed [wti_pkg::ANGLE_BITS-1:0] joint_2,
    input  logic signed [wti_pkg::ANGLE_BITS-1:0] joint_3,
    input  logic signed [wti_pkg::ANGLE_BITS-1:0] joint_4,
    input  logic signed [wti_pkg::ANGLE_BITS-1:0] joint_5,
    input  logic [wti_pkg::DT_W-1:0]            tick_dt,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [wti_pkg::JIDX_W-1:0]          joint_index,
    output logic signed [wti_pkg::ANGLE_BITS-1:0] joint_value,
    output logic                                joint_valid,
    output logic                                visible,
    output logic                                playing,
    output logic                                last,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wti_pkg::PADDR_W-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int AB = wti_pkg::ANGLE_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DUR,
        S_MOD,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_T0_RD,
        S_T0_CMP,
        S_DIV,
        S_ROW_A,
        S_ROW_B,
        S_ROW_W,
        S_J_MUL,
        S_J_OUT,
        S_STATUS
    } state_t;

    state_t                           state_reg;
    logic [wti_pkg::CNT_W-1:0]        count_reg;
    logic [wti_pkg::ELAP_W-1:0]       elapsed_reg;
    logic                             shown_reg;
    logic                             running_reg;
    logic                             loop_mode_reg;

    // sequencer working registers
    logic [wti_pkg::IDX_W-1:0]        nx_reg;
    logic [wti_pkg::IDX_W-1:0]        pv_reg;
    logic [wti_pkg::TIME_W-1:0]       t1_reg;
    logic [wti_pkg::TIME_W-1:0]       den_reg;
    logic [wti_pkg::TIME_W-1:0]       rem_reg;
    logic [wti_pkg::ELAP_W-1:0]       sh_reg;
    logic [5:0]                       cnt_reg;
    logic [wti_pkg::ALPHA_W-1:0]      q_reg;
    logic [wti_pkg::ROW_W-1:0]        row_a_reg;
    logic [wti_pkg::ROW_W-1:0]        row_b_reg;
    logic [wti_pkg::JIDX_W-1:0]       j_reg;
    logic signed [AB-1:0]             a_sel_reg;
    logic signed [AB+wti_pkg::ALPHA_W+1:0] prod_reg;

    // output register
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             out_load;
    logic [wti_pkg::JIDX_W-1:0]       joint_index_reg;
    logic signed [AB-1:0]             joint_value_reg;
    logic                             joint_valid_reg;
    logic                             visible_reg;
    logic                             playing_reg;
    logic                             last_reg;

    // tables
    logic                             tbl_we;
    logic [wti_pkg::IDX_W-1:0]        tbl_waddr;
    logic [wti_pkg::IDX_W-1:0]        t_raddr;
    logic [wti_pkg::IDX_W-1:0]        a_raddr;
    logic [wti_pkg::TIME_W-1:0]       t_rdata;
    logic [wti_pkg::ROW_W-1:0]        row_wdata;
    logic [wti_pkg::ROW_W-1:0]        row_rdata;
    logic signed [AB-1:0]             jin [6];

    logic                             in_take;
    logic                             out_free;
    logic [wti_pkg::CNT_W-1:0]        count_m1;
    logic [wti_pkg::IDX_W-1:0]        last_idx;
    logic [wti_pkg::IDX_W-1:0]        nx_m1;
    logic [wti_pkg::CNT_W-1:0]        nx_p1;
    logic [wti_pkg::ELAP_W-1:0]       elapsed_add;
    logic [wti_pkg::ELAP_W-1:0]       t_ext;
    logic [wti_pkg::ELAP_W-1:0]       num_w;
    logic [wti_pkg::TIME_W-1:0]       den_w;

    // shared shift-subtract unit
    logic [wti_pkg::TIME_W:0]         div_r2;
    logic                             div_ge;
    logic [wti_pkg::TIME_W:0]         div_sub;
    logic [wti_pkg::TIME_W-1:0]       div_rem;

    // interpolation
    logic signed [AB-1:0]             a_j;
    logic signed [AB-1:0]             b_j;
    logic signed [AB:0]               diff_j;
    logic signed [wti_pkg::ALPHA_W:0] alpha_s;
    logic signed [AB+wti_pkg::ALPHA_W+1:0] prod_rnd;
    logic signed [AB+2:0]             lerp_q;
    logic signed [AB+2:0]             lerp_sum;

    assign in_take   = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign count_m1  = count_reg - 1'b1;
    assign last_idx  = count_m1[wti_pkg::IDX_W-1:0];
    assign nx_m1     = nx_reg - 1'b1;
    assign nx_p1     = {1'b0, nx_reg} + 1'b1;
    assign elapsed_add = elapsed_reg + {{(wti_pkg::ELAP_W - wti_pkg::DT_W - 1){1'b0}},
                                        tick_dt, 1'b0};
    assign t_ext     = {2'b00, t_rdata};
    assign num_w     = elapsed_reg - t_ext;
    assign den_w     = t1_reg - t_rdata;

    // a new beat enters the output register, or the held one stays
    assign out_load       = out_free && ((state_reg == S_J_OUT) || (state_reg == S_STATUS));
    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    assign div_r2  = {rem_reg, sh_reg[wti_pkg::ELAP_W-1]};
    assign div_ge  = (div_r2 >= {1'b0, den_reg});
    assign div_sub = div_r2 - {1'b0, den_reg};
    assign div_rem = div_ge ? div_sub[wti_pkg::TIME_W-1:0] : div_r2[wti_pkg::TIME_W-1:0];

    assign a_j      = row_a_reg[j_reg*AB +: AB];
    assign b_j      = row_b_reg[j_reg*AB +: AB];
    assign diff_j   = {b_j[AB-1], b_j} - {a_j[AB-1], a_j};
    assign alpha_s  = $signed({1'b0, q_reg});
    assign prod_rnd = prod_reg + (AB + wti_pkg::ALPHA_W + 2)'(32768);
    assign lerp_q   = prod_rnd[AB+wti_pkg::ALPHA_W+1:16];
    assign lerp_sum = lerp_q + {{3{a_sel_reg[AB-1]}}, a_sel_reg};

    // append write
    assign jin[0] = joint_0;
    assign jin[1] = joint_1;
    assign jin[2] = joint_2;
    assign jin[3] = joint_3;
    assign jin[4] = joint_4;
    assign jin[5] = joint_5;

    always_comb
    begin
        row_wdata = '0;
        for (int j = 0; j < wti_pkg::NUM_JOINTS; j++)
        begin
            row_wdata[j*AB +: AB] = jin[j];
        end
    end

    assign tbl_we    = in_take && (func == wti_pkg::FUNC_APPEND)
                       && (count_reg < wti_pkg::CNT_W'(wti_pkg::MAX_POINTS));
    assign tbl_waddr = count_reg[wti_pkg::IDX_W-1:0];

    // read address selection
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  t_raddr = last_idx;
            S_T0_RD: t_raddr = nx_m1;
            default: t_raddr = nx_reg;
        endcase
        unique case (state_reg)
            S_ROW_A: a_raddr = pv_reg;
            default: a_raddr = nx_reg;
        endcase
    end

    wti_ram #(
        .WIDTH(wti_pkg::TIME_W),
        .DEPTH(wti_pkg::MAX_POINTS)
    ) u_time_ram (
        .clk  (clk),
        .we   (tbl_we),
        .waddr(tbl_waddr),
        .wdata(point_time),
        .raddr(t_raddr),
        .rdata(t_rdata)
    );

    wti_ram #(
        .WIDTH(wti_pkg::ROW_W),
        .DEPTH(wti_pkg::MAX_POINTS)
    ) u_angle_ram (
        .clk  (clk),
        .we   (tbl_we),
        .waddr(tbl_waddr),
        .wdata(row_wdata),
        .raddr(a_raddr),
        .rdata(row_rdata)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == wti_pkg::ADDR_LOOP_MODE) ? {31'b0, loop_mode_reg} : 32'b0;

    // sequencer, flags and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            elapsed_reg   <= '0;
            shown_reg     <= 1'b0;
            running_reg   <= 1'b0;
            loop_mode_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && (paddr == wti_pkg::ADDR_LOOP_MODE))
            begin
                loop_mode_reg <= pwdata[0];
            end

            out_valid_reg <= out_valid_next;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        case (func)
                            wti_pkg::FUNC_CLEAR:
                            begin
                                count_reg   <= '0;
                                elapsed_reg <= '0;
                                shown_reg   <= 1'b0;
                                running_reg <= 1'b0;
                            end
                            wti_pkg::FUNC_APPEND:
                            begin
                                if (tbl_we)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            wti_pkg::FUNC_START:
                            begin
                                elapsed_reg <= '0;
                                shown_reg   <= (count_reg != '0);
                                running_reg <= (count_reg != '0);
                            end
                            wti_pkg::FUNC_STOP:
                            begin
                                shown_reg   <= 1'b0;
                                running_reg <= 1'b0;
                            end
                            wti_pkg::FUNC_TICK:
                            begin
                                if (shown_reg && running_reg && (count_reg >= 2))
                                begin
                                    // duration read is under way
                                    elapsed_reg <= elapsed_add;
                                    state_reg   <= S_DUR;
                                end
                                else if (shown_reg && !running_reg && (count_reg != '0))
                                begin
                                    // hold the final point: alpha 0 on one row
                                    nx_reg    <= last_idx;
                                    pv_reg    <= last_idx;
                                    q_reg     <= '0;
                                    state_reg <= S_ROW_A;
                                end
                                else
                                begin
                                    state_reg <= S_STATUS;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                S_DUR:
                begin
                    nx_reg <= wti_pkg::IDX_W'(1);
                    if ((elapsed_reg >= t_ext) && loop_mode_reg && (t_rdata != '0))
                    begin
                        den_reg   <= t_rdata;
                        rem_reg   <= '0;
                        sh_reg    <= elapsed_reg;
                        cnt_reg   <= 6'(wti_pkg::ELAP_W);
                        state_reg <= S_MOD;
                    end
                    else
                    begin
                        state_reg <= S_SRCH_RD;
                        if (elapsed_reg >= t_ext)
                        begin
                            if (loop_mode_reg)
                            begin
                                // zero duration wraps to the start
                                elapsed_reg <= '0;
                            end
                            else
                            begin
                                elapsed_reg <= t_ext;
                                running_reg <= 1'b0;
                            end
                        end
                    end
                end

                S_MOD:
                begin
                    // elapsed mod duration, one dividend bit a cycle
                    rem_reg <= div_rem;
                    sh_reg  <= {sh_reg[wti_pkg::ELAP_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == 6'd1)
                    begin
                        elapsed_reg <= {2'b00, div_rem};
                        state_reg   <= S_SRCH_RD;
                    end
                end

                S_SRCH_RD:
                begin
                    state_reg <= S_SRCH_CMP;
                end

                S_SRCH_CMP:
                begin
                    if ((t_ext < elapsed_reg) && (nx_p1 < count_reg))
                    begin
                        nx_reg    <= nx_p1[wti_pkg::IDX_W-1:0];
                        state_reg <= S_SRCH_RD;
                    end
                    else
                    begin
                        t1_reg    <= t_rdata;
                        state_reg <= S_T0_RD;
                    end
                end

                S_T0_RD:
                begin
                    pv_reg    <= nx_m1;
                    state_reg <= S_T0_CMP;
                end

                S_T0_CMP:
                begin
                    if ((t1_reg > t_rdata) && (elapsed_reg > t_ext)
                        && (num_w < {2'b00, den_w}))
                    begin
                        q_reg     <= '0;
                        den_reg   <= den_w;
                        rem_reg   <= num_w[wti_pkg::TIME_W-1:0];
                        sh_reg    <= '0;
                        cnt_reg   <= 6'(wti_pkg::ALPHA_W - 1);
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_ROW_A;
                        if ((t1_reg > t_rdata) && (elapsed_reg > t_ext))
                        begin
                            q_reg <= wti_pkg::ALPHA_ONE;
                        end
                        else
                        begin
                            q_reg <= '0;
                        end
                    end
                end

                S_DIV:
                begin
                    // alpha quotient, one bit a cycle on the same unit
                    rem_reg <= div_rem;
                    q_reg   <= {q_reg[wti_pkg::ALPHA_W-2:0], div_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == 6'd1)
                    begin
                        state_reg <= S_ROW_A;
                    end
                end

                S_ROW_A:
                begin
                    state_reg <= S_ROW_B;
                end

                S_ROW_B:
                begin
                    row_a_reg <= row_rdata;
                    state_reg <= S_ROW_W;
                end

                S_ROW_W:
                begin
                    row_b_reg <= row_rdata;
                    j_reg     <= '0;
                    state_reg <= S_J_MUL;
                end

                S_J_MUL:
                begin
                    prod_reg  <= diff_j * alpha_s;
                    a_sel_reg <= a_j;
                    state_reg <= S_J_OUT;
                end

                S_J_OUT:
                begin
                    if (out_free)
                    begin
                        joint_index_reg <= j_reg;
                        joint_value_reg <= lerp_sum[AB-1:0];
                        joint_valid_reg <= 1'b1;
                        visible_reg     <= shown_reg;
                        playing_reg     <= running_reg;
                        if (j_reg == wti_pkg::JIDX_W'(wti_pkg::NUM_JOINTS - 1))
                        begin
                            last_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            last_reg  <= 1'b0;
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_J_MUL;
                        end
                    end
                end

                S_STATUS:
                begin
                    if (out_free)
                    begin
                        joint_index_reg <= '0;
                        joint_value_reg <= '0;
                        joint_valid_reg <= 1'b0;
                        visible_reg     <= shown_reg;
                        playing_reg     <= running_reg;
                        last_reg        <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign joint_index = joint_index_reg;
    assign joint_value = joint_value_reg;
    assign joint_valid = joint_valid_reg;
    assign visible     = visible_reg;
    assign playing     = playing_reg;
    assign last        = last_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= wti_pkg::CNT_W'(wti_pkg::MAX_POINTS))
        else $error("point count above capacity");

    a_running_shown: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> shown_reg)
        else $error("running without shown");

    a_search_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH_CMP) |-> ({1'b0, nx_reg} < count_reg))
        else $error("segment search left the table");

    a_alpha_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROW_A) |-> (q_reg <= wti_pkg::ALPHA_ONE))
        else $error("alpha above one");

    a_elapsed_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH_RD) && $past(state_reg == S_MOD) |->
            (elapsed_reg < {2'b00, den_reg}))
        else $error("wrapped time not below duration");

endmodule

### bench/waypoint_trajectory_interpolator_top_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the waypoint trajectory interpolator: table loading, playback
// ticks in hold and loop mode, stop and clear, with random idling on both channels
// depends on wti_pkg and the design files

module waypoint_trajectory_interpolator_top_tb;

    typedef struct packed {
        logic [wti_pkg::JIDX_W-1:0]     jidx;
        logic [wti_pkg::ANGLE_BITS-1:0] jval;
        logic                           jvld;
        logic                           vis;
        logic                           play;
        logic                           lst;
    } joint_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [wti_pkg::FUNC_W-1:0] func = wti_pkg::FUNC_CLEAR;
    logic [wti_pkg::TIME_W-1:0] point_time = '0;
    logic signed [wti_pkg::ANGLE_BITS-1:0] joint_0 = '0, joint_1 = '0, joint_2 = '0;
    logic signed [wti_pkg::ANGLE_BITS-1:0] joint_3 = '0, joint_4 = '0, joint_5 = '0;
    logic [wti_pkg::DT_W-1:0] tick_dt = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [wti_pkg::JIDX_W-1:0] joint_index;
    logic signed [wti_pkg::ANGLE_BITS-1:0] joint_value;
    logic joint_valid, visible, playing, last;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [wti_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    waypoint_trajectory_interpolator_top DUT (.*);

    always #10 clk = ~clk;

    // predictor state, mirrors the block's control state and tables
    logic [wti_pkg::TIME_W-1:0]     wp_time [wti_pkg::MAX_POINTS];
    logic [wti_pkg::ANGLE_BITS-1:0] wp_ang  [wti_pkg::MAX_POINTS][wti_pkg::NUM_JOINTS];
    int unsigned                    wp_count;
    logic [wti_pkg::ELAP_W-1:0]     play_pos;
    bit                             shown, running;
    bit                             loop_on;

    joint_beat_t pending_beats[$];
    int  mismatches;
    int  beats_seen;
    int  items_sent;
    bit  no_idle;       // long stretch with neither side idling

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic logic [wti_pkg::ANGLE_BITS-1:0] blend(
        logic [wti_pkg::ANGLE_BITS-1:0] a,
        logic [wti_pkg::ANGLE_BITS-1:0] b,
        longint alpha);
        longint sa, sb, prod;
        sa = longint'(signed'(a));
        sb = longint'(signed'(b));
        prod = (sb - sa) * alpha + 32768;
        // arithmetic shift is floor division by 65536
        return wti_pkg::ANGLE_BITS'(sa + (prod >>> 16));
    endfunction

    task automatic queue_beat(int j, logic [wti_pkg::ANGLE_BITS-1:0] v, bit vld, bit lst);
        joint_beat_t b;
        b.jidx = wti_pkg::JIDX_W'(j);
        b.jval = v;
        b.jvld = vld;
        b.vis  = shown;
        b.play = running;
        b.lst  = lst;
        pending_beats = {pending_beats, b};
    endtask

    task automatic predict_tick(logic [wti_pkg::DT_W-1:0] dt);
        longint unsigned dur, t0, t1, num, den, alpha, pos;
        int nx, pv;
        if (shown && running && wp_count >= 2)
        begin
            dur = wp_time[wp_count-1];
            play_pos = wti_pkg::ELAP_W'(play_pos + 2 * dt);
            pos = play_pos;
            if (pos >= dur)
            begin
                if (loop_on)
                begin
                    pos = (dur == 0) ? 0 : pos % dur;
                end
                else
                begin
                    pos = dur;
                    running = 1'b0;
                end
                play_pos = wti_pkg::ELAP_W'(pos);
            end
            nx = 1;
            while (nx < wp_count && wp_time[nx] < pos) nx++;
            if (nx >= wp_count) nx = wp_count - 1;
            pv = nx - 1;
            t0 = wp_time[pv];
            t1 = wp_time[nx];
            alpha = 0;
            if (t1 > t0 && pos > t0)
            begin
                num = pos - t0;
                den = t1 - t0;
                alpha = (num >= den) ? 65536 : (num << 16) / den;
            end
            for (int j = 0; j < wti_pkg::NUM_JOINTS; j++)
                queue_beat(j, blend(wp_ang[pv][j], wp_ang[nx][j], alpha), 1'b1,
                           j == wti_pkg::NUM_JOINTS - 1);
        end
        else if (shown && wp_count > 0 && !running)
        begin
            for (int j = 0; j < wti_pkg::NUM_JOINTS; j++)
                queue_beat(j, wp_ang[wp_count-1][j], 1'b1, j == wti_pkg::NUM_JOINTS - 1);
        end
        else
            queue_beat(0, '0, 1'b0, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------
    task automatic send_item(logic [wti_pkg::FUNC_W-1:0] f, logic [wti_pkg::TIME_W-1:0] t,
                             logic [wti_pkg::ANGLE_BITS-1:0] a[wti_pkg::NUM_JOINTS],
                             logic [wti_pkg::DT_W-1:0] dt);
        while (!no_idle && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        func       <= f;
        point_time <= t;
        joint_0 <= a[0]; joint_1 <= a[1]; joint_2 <= a[2];
        joint_3 <= a[3]; joint_4 <= a[4]; joint_5 <= a[5];
        tick_dt    <= dt;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        // beat accepted at this edge, update the predictor
        case (f)
            wti_pkg::FUNC_CLEAR:
            begin
                wp_count = 0; play_pos = '0; shown = 0; running = 0;
            end
            wti_pkg::FUNC_APPEND:
            begin
                if (wp_count < wti_pkg::MAX_POINTS)
                begin
                    wp_time[wp_count] = t;
                    for (int j = 0; j < wti_pkg::NUM_JOINTS; j++) wp_ang[wp_count][j] = a[j];
                    wp_count++;
                end
            end
            wti_pkg::FUNC_START:
            begin
                play_pos = '0; shown = wp_count > 0; running = wp_count > 0;
            end
            wti_pkg::FUNC_TICK: predict_tick(dt);
            wti_pkg::FUNC_STOP:
            begin
                shown = 0; running = 0;
            end
            default: ;
        endcase
        items_sent++;
        @(negedge clk);
    endtask

    function automatic logic [wti_pkg::ANGLE_BITS-1:0] rand_angle();
        case ($urandom_range(5))
            0: return {1'b1, {(wti_pkg::ANGLE_BITS-1){1'b0}}};
            1: return {1'b0, {(wti_pkg::ANGLE_BITS-1){1'b1}}};
            default: return wti_pkg::ANGLE_BITS'($urandom);
        endcase
    endfunction

    task automatic append_point(logic [wti_pkg::TIME_W-1:0] t);
        logic [wti_pkg::ANGLE_BITS-1:0] a[wti_pkg::NUM_JOINTS];
        foreach (a[j]) a[j] = rand_angle();
        send_item(wti_pkg::FUNC_APPEND, t, a, '0);
    endtask

    task automatic send_ctrl(logic [wti_pkg::FUNC_W-1:0] f, logic [wti_pkg::DT_W-1:0] dt);
        logic [wti_pkg::ANGLE_BITS-1:0] a[wti_pkg::NUM_JOINTS];
        foreach (a[j]) a[j] = wti_pkg::ANGLE_BITS'($urandom);
        send_item(f, $urandom, a, dt);
    endtask

    // wait until all results are back plus the longest playing tick
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_beats.size() != 0) @(negedge clk);
        repeat (600) @(negedge clk);
    endtask

    task automatic write_loop_mode(bit v);
        drain();
        psel <= 1'b1; pwrite <= 1'b1; paddr <= wti_pkg::ADDR_LOOP_MODE;
        pwdata <= {31'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        loop_on = v;
    endtask

    // ------------------------------------------------------------------
    // output side: random stall and the checker
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_stall <= !no_idle && ($urandom_range(99) < 36);

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch beat %0d: %s got %0h expected %0h", beats_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        joint_beat_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_beats.size() == 0)
            begin
                $display("unexpected result beat, joint_index %0d", joint_index);
                mismatches++;
            end
            else
            begin
                e = pending_beats.pop_front();
                if (joint_index !== e.jidx) report_mismatch("joint_index", joint_index, e.jidx);
                if (joint_value !== e.jval) report_mismatch("joint_value", joint_value, e.jval);
                if (joint_valid !== e.jvld) report_mismatch("joint_valid", joint_valid, e.jvld);
                if (visible !== e.vis)      report_mismatch("visible", visible, e.vis);
                if (playing !== e.play)     report_mismatch("playing", playing, e.play);
                if (last !== e.lst)         report_mismatch("last", last, e.lst);
            end
            beats_seen++;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // ticks with no table, single point, unknown codes, start on empty table
    task automatic test_empty_and_single();
        send_ctrl(wti_pkg::FUNC_TICK, 16'hFFFF);
        send_ctrl(wti_pkg::FUNC_START, '0);
        send_ctrl(wti_pkg::FUNC_TICK, 16'h0001);
        send_ctrl(3'd5, '0);
        send_ctrl(3'd6, '0);
        send_ctrl(3'd7, '0);
        append_point(32'h0001_0000);
        send_ctrl(wti_pkg::FUNC_START, '0);
        send_ctrl(wti_pkg::FUNC_TICK, 16'h1000);   // started with one point: status only
    endtask

    // hold mode: a short trajectory run past its end, then stop
    task automatic test_hold_playback();
        send_ctrl(wti_pkg::FUNC_CLEAR, '0);
        append_point(32'h0000_0000);
        append_point(32'h0000_0000);      // zero-length segment
        append_point(32'h0000_8000);
        append_point(32'hFFFF_FFFF);      // far end of the time range
        send_ctrl(wti_pkg::FUNC_START, '0);
        send_ctrl(wti_pkg::FUNC_TICK, 16'h0000);
        send_ctrl(wti_pkg::FUNC_TICK, 16'h2000);
        send_ctrl(wti_pkg::FUNC_TICK, 16'hFFFF);
        send_ctrl(wti_pkg::FUNC_CLEAR, '0);
        append_point(32'h0000_0000);
        append_point(32'h0000_0100);
        send_ctrl(wti_pkg::FUNC_START, '0);
        send_ctrl(wti_pkg::FUNC_TICK, 16'hFFFF);   // past the end: holds and stops
        send_ctrl(wti_pkg::FUNC_TICK, 16'h0010);   // stopped, final point again
        send_ctrl(wti_pkg::FUNC_STOP, '0);
        send_ctrl(wti_pkg::FUNC_TICK, 16'h0010);
    endtask

    // loop mode, including a trajectory whose duration is zero
    task automatic test_loop_playback();
        write_loop_mode(1'b1);
        send_ctrl(wti_pkg::FUNC_CLEAR, '0);
        append_point(32'h0000_0000);
        append_point(32'h0000_0000);
        send_ctrl(wti_pkg::FUNC_START, '0);
        send_ctrl(wti_pkg::FUNC_TICK, 16'h0123);
        send_ctrl(wti_pkg::FUNC_CLEAR, '0);
        append_point(32'h0000_0010);
        append_point(32'h0000_0300);
        append_point(32'h0000_0700);
        send_ctrl(wti_pkg::FUNC_START, '0);
        repeat (6) send_ctrl(wti_pkg::FUNC_TICK, wti_pkg::DT_W'($urandom_range(16'h0400)));
    endtask

    // fill past capacity so the extra points are dropped; few ticks, search is long
    task automatic test_full_table();
        logic [wti_pkg::TIME_W-1:0] t;
        write_loop_mode(1'b0);
        send_ctrl(wti_pkg::FUNC_CLEAR, '0);
        t = 0;
        for (int i = 0; i < wti_pkg::MAX_POINTS + 3; i++)
        begin
            append_point(t);
            t = t + $urandom_range(32'h40, 0);
        end
        send_ctrl(wti_pkg::FUNC_START, '0);
        repeat (3) send_ctrl(wti_pkg::FUNC_TICK, wti_pkg::DT_W'($urandom));
        send_ctrl(wti_pkg::FUNC_TICK, 16'hFFFF);
    endtask

    // mostly well-formed trajectories with random content, plus noise
    task automatic test_random_sessions(int items);
        int stop_at;
        logic [wti_pkg::TIME_W-1:0] t;
        int n;
        stop_at = items_sent + items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(9) == 0)
            begin
                no_idle = ~no_idle;
            end
            if ($urandom_range(7) == 0)
            begin
                write_loop_mode($urandom_range(1));
            end
            if ($urandom_range(4) == 0)
            begin
                // noise: any code, any content
                send_ctrl(wti_pkg::FUNC_W'($urandom_range(7)), wti_pkg::DT_W'($urandom));
            end
            else
            begin
                send_ctrl(wti_pkg::FUNC_CLEAR, '0);
                n = $urandom_range(8, 1);
                t = $urandom_range(1) ? '0 : wti_pkg::TIME_W'($urandom_range(32'h800));
                for (int i = 0; i < n; i++)
                begin
                    append_point($urandom_range(15) == 0 ? wti_pkg::TIME_W'($urandom) : t);
                    t = t + $urandom_range(32'h2000);
                end
                send_ctrl(wti_pkg::FUNC_START, '0);
                repeat ($urandom_range(8, 2))
                    send_ctrl($urandom_range(12) == 0 ? wti_pkg::FUNC_STOP
                                                      : wti_pkg::FUNC_TICK,
                              $urandom_range(3) == 0
                                  ? wti_pkg::DT_W'($urandom)
                                  : wti_pkg::DT_W'($urandom_range(16'h0800)));
            end
        end
    endtask

    initial
    begin
        wp_count = 0; play_pos = '0; shown = 0; running = 0; loop_on = 0;
        mismatches = 0; beats_seen = 0; items_sent = 0; no_idle = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_and_single();
        test_hold_playback();
        test_loop_playback();
        test_full_table();
        test_random_sessions(140);
        drain();

        $display("covered %0d input beats and %0d result beats across hold and loop playback",
                 items_sent, beats_seen);
        if (mismatches == 0 && pending_beats.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #(40_000_000);
        $display("timeout with %0d result beats outstanding", pending_beats.size());
        $display("status: fail");
        $finish;
    end

endmodule

### sim.f
design/wti_pkg.sv
design/wti_ram.sv
design/waypoint_trajectory_interpolator_top.sv
bench/waypoint_trajectory_interpolator_top_tb.sv
